>>> rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the line stepper: request and pixel
// payloads, the setup command passed from front to back, and field widths.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS    = 8;
    localparam int COLOR_BITS    = 16;
    localparam int ERR_BITS      = COORD_BITS + 3;
    localparam int MINC_BITS     = COORD_BITS + 2;
    localparam int STEP_BITS     = COORD_BITS + 1;
    localparam int CMD_DEPTH_DEF = 2;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic
    {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_e;

    // step direction per axis, two's complement -1, 0, +1
    typedef enum logic [1:0]
    {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b11
    } dir_e;

    typedef struct packed
    {
        action_e action;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
        color_t  line_color;
    } in_item_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } out_item_t;

    typedef struct packed
    {
        logic   is_start;
        coord_t x0;
        coord_t y0;
        coord_t major;
        coord_t minor;
        dir_e   dir_x;
        dir_e   dir_y;
        logic   x_major;
        color_t color;
    } cmd_t;

    typedef struct packed
    {
        logic line_active;
        logic out_load;
        logic cmd_take;
    } back_stat_t;

endpackage

>>> rtl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer line rasterizer: start requests load a line, step requests return
// one pixel each until the end point.
// ----------------------------------------------------------------------------
// A start request (action 0) loads two endpoints and a colour and gives no
// pixel; each step request (action 1) then gives one pixel, from the first
// endpoint to the second inclusive, with last_pixel set on the end point.
// Step requests with no line running are dropped, and a start replaces any
// running line. The block takes one request per clock while full is low: the
// front computes the axis setup in the accept cycle and writes a command
// queue of CMD_DEPTH entries; the back retires one command per clock, while
// the result register is empty or popped. A step's pixel passes the queue
// entry, then the result register, and both hold on a stall; with pop high
// the sustained rate is one request per clock and one pixel per step request.
// ----------------------------------------------------------------------------
module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t pixel
);

    cmd_t       front_cmd;
    cmd_t       back_cmd;
    logic       cmd_valid;
    logic       cmd_take;
    logic       wr_en;
    back_stat_t stat;

    assign wr_en = push && !full;

    bls_front u_front
    (
        .item (item),
        .cmd  (front_cmd)
    );

    bls_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (cmd_take),
        .rd_data  (back_cmd),
        .rd_valid (cmd_valid)
    );

    bls_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .stat      (stat)
    );

    // an accepted request is waiting in the queue on the next clock
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !cmd_take) |=> cmd_valid)
        else $error("accepted request missing from command queue");

    // a start or a step with no line running never yields a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && (back_cmd.is_start || !stat.line_active) && (empty || pop))
        |=> empty)
        else $error("pixel produced without a running line");

    // a pixel is only loaded while a line runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.out_load && !stat.line_active) |-> 1'b0)
        else $error("pixel loaded with no line running");

    // the end point closes the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.out_load) |=> (!empty && (pixel.last_pixel == !stat.line_active)))
        else $error("last pixel flag disagrees with line state");

endmodule

>>> rtl/bls_front.sv
// ----------------------------------------------------------------------------
// bls_front
// Classifies requests and does the axis setup of a start request: extents,
// step directions and choice of major axis.
// ----------------------------------------------------------------------------
module bls_front
    import bls_pkg::*;
(
    input  in_item_t item,
    output cmd_t     cmd
);

    logic [COORD_BITS:0]   diff_x;
    logic [COORD_BITS:0]   diff_y;
    logic [COORD_BITS:0]   neg_x;
    logic [COORD_BITS:0]   neg_y;
    coord_t                ext_x;
    coord_t                ext_y;
    logic                  x_major;

    always_comb
    begin
        diff_x = {1'b0, item.end_x} - {1'b0, item.start_x};
        diff_y = {1'b0, item.end_y} - {1'b0, item.start_y};
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        ext_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
        ext_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
        // equal extents keep x as major
        x_major = !(ext_x < ext_y);

        cmd.is_start = (item.action == ACT_START);
        cmd.x0       = item.start_x;
        cmd.y0       = item.start_y;
        cmd.major    = x_major ? ext_x : ext_y;
        cmd.minor    = x_major ? ext_y : ext_x;
        cmd.x_major  = x_major;
        cmd.color    = item.line_color;

        if (diff_x == '0)
            cmd.dir_x = DIR_NONE;
        else if (diff_x[COORD_BITS])
            cmd.dir_x = DIR_NEG;
        else
            cmd.dir_x = DIR_POS;

        if (diff_y == '0)
            cmd.dir_y = DIR_NONE;
        else if (diff_y[COORD_BITS])
            cmd.dir_y = DIR_NEG;
        else
            cmd.dir_y = DIR_POS;
    end

endmodule

>>> rtl/bls_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bls_cmd_fifo
// Short command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module bls_cmd_fifo
    import bls_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic rd_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data  = entry_reg[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == CNT_W'(DEPTH));

endmodule

>>> rtl/bls_back.sv
// ----------------------------------------------------------------------------
// bls_back
// Line state and per-pixel stepping, with the result register in front of
// the output queue ports.
// ----------------------------------------------------------------------------
module bls_back
    import bls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_valid,
    output logic       cmd_take,
    output out_item_t  pixel,
    output logic       empty,
    input  logic       pop,
    output back_stat_t stat
);

    coord_t                cur_x_reg,  cur_x_next;
    coord_t                cur_y_reg,  cur_y_next;
    logic [ERR_BITS-1:0]   err_reg,    err_next;
    logic [MINC_BITS-1:0]  minc_reg,   minc_next;
    logic [ERR_BITS-1:0]   diag_reg,   diag_next;
    logic [STEP_BITS-1:0]  steps_reg,  steps_next;
    dir_e                  dir_x_reg,  dir_x_next;
    dir_e                  dir_y_reg,  dir_y_next;
    logic                  xmaj_reg,   xmaj_next;
    color_t                color_reg,  color_next;
    logic                  active_reg, active_next;
    out_item_t             out_reg,    out_next;
    logic                  outv_reg,   outv_next;

    logic                  out_load;
    logic                  last;
    coord_t                step_x;
    coord_t                step_y;
    logic [ERR_BITS-1:0]   minc_ext;
    logic [ERR_BITS-1:0]   major_ext;
    logic [ERR_BITS-1:0]   minor_ext;

    always_comb
    begin
        cmd_take  = cmd_valid && (!outv_reg || pop);
        out_load  = cmd_take && !cmd.is_start && active_reg;
        last      = (steps_reg == '0);
        step_x    = {{(COORD_BITS-2){dir_x_reg[1]}}, dir_x_reg};
        step_y    = {{(COORD_BITS-2){dir_y_reg[1]}}, dir_y_reg};
        minc_ext  = ERR_BITS'(minc_reg);
        major_ext = ERR_BITS'(cmd.major);
        minor_ext = ERR_BITS'(cmd.minor);

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        minc_next   = minc_reg;
        diag_next   = diag_reg;
        steps_next  = steps_reg;
        dir_x_next  = dir_x_reg;
        dir_y_next  = dir_y_reg;
        xmaj_next   = xmaj_reg;
        color_next  = color_reg;
        active_next = active_reg;
        out_next    = out_reg;
        outv_next   = outv_reg && !pop;

        if (cmd_take && cmd.is_start)
        begin
            cur_x_next  = cmd.x0;
            cur_y_next  = cmd.y0;
            minc_next   = {1'b0, cmd.minor, 1'b0};
            err_next    = {minor_ext[ERR_BITS-2:0], 1'b0} - major_ext;
            diag_next   = {(minor_ext[ERR_BITS-2:0] - major_ext[ERR_BITS-2:0]), 1'b0};
            steps_next  = {1'b0, cmd.major};
            dir_x_next  = cmd.dir_x;
            dir_y_next  = cmd.dir_y;
            xmaj_next   = cmd.x_major;
            color_next  = cmd.color;
            active_next = 1'b1;
        end
        else if (out_load)
        begin
            out_next.pixel_x     = cur_x_reg;
            out_next.pixel_y     = cur_y_reg;
            out_next.pixel_color = color_reg;
            out_next.last_pixel  = last;
            outv_next            = 1'b1;
            if (last)
                active_next = 1'b0;
            else
            begin
                steps_next = steps_reg - 1'b1;
                // negative error: major axis only, otherwise diagonal move
                if (err_reg[ERR_BITS-1])
                begin
                    err_next = err_reg + minc_ext;
                    if (xmaj_reg)
                        cur_x_next = cur_x_reg + step_x;
                    else
                        cur_y_next = cur_y_reg + step_y;
                end
                else
                begin
                    err_next   = err_reg + diag_reg;
                    cur_x_next = cur_x_reg + step_x;
                    cur_y_next = cur_y_reg + step_y;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            outv_reg   <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        err_reg   <= err_next;
        minc_reg  <= minc_next;
        diag_reg  <= diag_next;
        steps_reg <= steps_next;
        dir_x_reg <= dir_x_next;
        dir_y_reg <= dir_y_next;
        xmaj_reg  <= xmaj_next;
        color_reg <= color_next;
        out_reg   <= out_next;
    end

    assign pixel = out_reg;
    assign empty = !outv_reg;

    assign stat.line_active = active_reg;
    assign stat.out_load    = out_load;
    assign stat.cmd_take    = cmd_take;

endmodule
